// File: rtl/core/oadc_pkg.sv
// Shared constants and codes for the obstacle-avoiding drive controller.
package oadc_pkg;

  localparam int DistW  = 7;
  localparam int TimeW  = 32;
  localparam int PeriodW = 16;
  localparam int PctW   = 7;
  localparam int DirW   = 3;
  localparam int PhaseW = 2;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  localparam logic [DistW-1:0] DIST_CAP     = 7'd100;
  localparam logic [DistW-1:0] OPEN_SIDE_CM = 7'd70;
  localparam logic [DistW:0]   DIFF_LIMIT   = 8'd6;
  localparam logic [PctW-1:0]  SETPOINT_RESET = 7'd80;

  localparam logic [7:0] CMD_AUTO   = 8'h41;
  localparam logic [7:0] CMD_MANUAL = 8'h50;
  localparam logic [7:0] CMD_FRONT  = 8'h46;
  localparam logic [7:0] CMD_FRONT2 = 8'h51;
  localparam logic [7:0] CMD_BACK   = 8'h42;
  localparam logic [7:0] CMD_BACK2  = 8'h57;
  localparam logic [7:0] CMD_LEFT   = 8'h4C;
  localparam logic [7:0] CMD_LEFT2  = 8'h45;
  localparam logic [7:0] CMD_RIGHT  = 8'h52;
  localparam logic [7:0] CMD_RIGHT2 = 8'h54;

  localparam logic [DirW-1:0] DIR_STOP  = 3'd0;
  localparam logic [DirW-1:0] DIR_FRONT = 3'd1;
  localparam logic [DirW-1:0] DIR_BACK  = 3'd2;
  localparam logic [DirW-1:0] DIR_LEFT  = 3'd3;
  localparam logic [DirW-1:0] DIR_RIGHT = 3'd4;

  localparam logic [PhaseW-1:0] PH_STOP  = 2'd0;
  localparam logic [PhaseW-1:0] PH_SCAN  = 2'd1;
  localparam logic [PhaseW-1:0] PH_AVOID = 2'd2;
  localparam logic [PhaseW-1:0] PH_BACK  = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_CRASH     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BLOCK_FR  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BLOCK_SD  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_WALL      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BACK_TIME = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_AVOID_TIME = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_DERATE    = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_MIN_SPEED = 3'd7;

  // Clamp a raw echo distance: no echo or beyond range counts as the cap.
  function automatic logic [DistW-1:0] clamp_dist(input logic [7:0] d);
    logic [DistW-1:0] res;
    if (d == 8'd0 || d > {1'b0, DIST_CAP}) begin
      res = DIST_CAP;
    end else begin
      res = d[DistW-1:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/core/obstacle_avoid_drive_controller.sv
// Top level of the obstacle-avoiding drive controller: one control-loop pass per word.
//
// Each input word is one control-loop pass and yields exactly one result word.
// A word is captured in an input register, where a single pass of short
// combinational logic derates the speed setpoint, takes the optional command
// byte and runs either manual control or the scan, avoid and back phase
// machine; the loop state and the result register load together once the
// result register is free. A new word can be accepted every cycle while the
// result channel does not stall; each pass reads and writes the loop state,
// which is updated as its result word loads. Both channels stall cleanly: the
// input register refills as soon as the result register is free or is being
// emptied. The configuration registers reset to their documented values and
// should only be written while no word is in flight.
module obstacle_avoid_drive_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [oadc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [oadc_pkg::CfgDataW-1:0] cfg_wdata,
  // Input channel.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [31:0]                   in_now_ms,
  input  logic [7:0]                    in_dist_left_cm,
  input  logic [7:0]                    in_dist_center_cm,
  input  logic [7:0]                    in_dist_right_cm,
  input  logic                          in_temp_danger,
  input  logic                          in_gas_danger,
  input  logic                          in_battery_danger,
  input  logic                          in_cmd_valid,
  input  logic [7:0]                    in_cmd_byte,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_drive_issue,
  output logic [2:0]                    out_drive_dir,
  output logic [6:0]                    out_drive_pct,
  output logic                          out_echo_valid,
  output logic [7:0]                    out_echo_byte,
  output logic [1:0]                    out_danger_total,
  output logic [2:0]                    out_reduction_pct,
  output logic                          out_tracker_enable
);
  import oadc_pkg::*;

  // Configuration registers.
  logic [DistW-1:0]   crash_cm_r, block_front_r, block_side_r, wall_margin_r, min_speed_r;
  logic [PeriodW-1:0] back_time_r, avoid_time_r, derate_period_r;

  // Input stage.
  logic             s1_valid_r;
  logic [TimeW-1:0] s1_now_r;
  logic [7:0]       s1_dl_r, s1_dc_r, s1_dr_r;
  logic             s1_temp_r, s1_gas_r, s1_batt_r;
  logic             s1_cmd_valid_r;
  logic [7:0]       s1_cmd_r;

  // Loop state.
  logic              auto_mode_r, auto_mode_nxt;
  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [TimeW-1:0]  phase_start_r, phase_start_nxt;
  logic [7:0]        last_cmd_r, last_cmd_nxt;
  logic [PctW-1:0]   setpoint_r, setpoint_nxt;
  logic [PctW-1:0]   applied_r, applied_nxt;
  logic [TimeW-1:0]  derate_start_r, derate_start_nxt;

  // Result register.
  logic            out_valid_r;
  logic            issue_r, issue_nxt;
  logic [DirW-1:0] dir_r, dir_nxt;
  logic [PctW-1:0] pct_r, pct_nxt;
  logic            echo_valid_r;
  logic [7:0]      echo_byte_r;
  logic [1:0]      dangers_r;
  logic [2:0]      step_r;
  logic            tracker_r;

  // Pass datapath.
  logic             out_free, fire;
  logic [DistW-1:0] dl, dc, dr, fmin;
  logic [1:0]       dangers;
  logic [2:0]       step;
  logic [TimeW-1:0] derate_elapsed, phase_elapsed;
  logic [DistW:0]   floor_sum;
  logic             run_manual;

  assign out_free = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crash_cm_r      <= 7'd10;
      block_front_r   <= 7'd30;
      block_side_r    <= 7'd20;
      wall_margin_r   <= 7'd15;
      back_time_r     <= 16'd250;
      avoid_time_r    <= 16'd40;
      derate_period_r <= 16'd1000;
      min_speed_r     <= 7'd30;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CRASH:      crash_cm_r      <= cfg_wdata[DistW-1:0];
        REG_BLOCK_FR:   block_front_r   <= cfg_wdata[DistW-1:0];
        REG_BLOCK_SD:   block_side_r    <= cfg_wdata[DistW-1:0];
        REG_WALL:       wall_margin_r   <= cfg_wdata[DistW-1:0];
        REG_BACK_TIME:  back_time_r     <= cfg_wdata;
        REG_AVOID_TIME: avoid_time_r    <= cfg_wdata;
        REG_DERATE:     derate_period_r <= cfg_wdata;
        REG_MIN_SPEED:  min_speed_r     <= cfg_wdata[DistW-1:0];
        default: begin
        end
      endcase
    end
  end

  // The input register loads whenever it is empty or drains this cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_now_r       <= in_now_ms;
      s1_dl_r        <= in_dist_left_cm;
      s1_dc_r        <= in_dist_center_cm;
      s1_dr_r        <= in_dist_right_cm;
      s1_temp_r      <= in_temp_danger;
      s1_gas_r       <= in_gas_danger;
      s1_batt_r      <= in_battery_danger;
      s1_cmd_valid_r <= in_cmd_valid;
      s1_cmd_r       <= in_cmd_byte;
    end
  end

  // Clamped distances, nearest reading and danger count.
  always_comb begin
    dl = clamp_dist(s1_dl_r);
    dc = clamp_dist(s1_dc_r);
    dr = clamp_dist(s1_dr_r);
    fmin = dc;
    if (dl < fmin) begin
      fmin = dl;
    end
    if (dr < fmin) begin
      fmin = dr;
    end
    dangers = 2'({1'b0, s1_temp_r} + {1'b0, s1_gas_r} + {1'b0, s1_batt_r});
    case (dangers)
      2'd0:    step = 3'd0;
      2'd1:    step = 3'd1;
      2'd2:    step = 3'd3;
      default: step = 3'd5;
    endcase
    derate_elapsed = s1_now_r - derate_start_r;
    phase_elapsed  = s1_now_r - phase_start_r;
    floor_sum      = {1'b0, min_speed_r} + {5'd0, step};
  end

  // One control-loop pass. Derating comes first so that any motor command
  // in this pass already uses the reduced setpoint.
  always_comb begin
    auto_mode_nxt    = auto_mode_r;
    phase_nxt        = phase_r;
    phase_start_nxt  = phase_start_r;
    last_cmd_nxt     = last_cmd_r;
    setpoint_nxt     = setpoint_r;
    applied_nxt      = applied_r;
    derate_start_nxt = derate_start_r;
    issue_nxt        = 1'b0;
    dir_nxt          = DIR_STOP;
    pct_nxt          = '0;

    // The derate timer only runs while the car moves under some danger.
    if (applied_r == '0 || dangers == 2'd0) begin
      derate_start_nxt = s1_now_r;
    end else if (derate_elapsed >= {16'd0, derate_period_r}) begin
      derate_start_nxt = s1_now_r;
      if ({1'b0, setpoint_r} > floor_sum) begin
        setpoint_nxt = setpoint_r - {4'd0, step};
      end else begin
        setpoint_nxt = min_speed_r;
      end
    end

    // Mode selection from a fresh command byte.
    if (s1_cmd_valid_r) begin
      last_cmd_nxt = s1_cmd_r;
      if (s1_cmd_r == CMD_AUTO) begin
        auto_mode_nxt = 1'b1;
        phase_nxt     = PH_SCAN;
        applied_nxt   = '0;
      end else if (s1_cmd_r == CMD_MANUAL) begin
        issue_nxt     = 1'b1;
        dir_nxt       = DIR_STOP;
        auto_mode_nxt = 1'b0;
        phase_nxt     = PH_SCAN;
        applied_nxt   = '0;
      end
    end

    run_manual = !auto_mode_nxt && last_cmd_nxt != CMD_AUTO && last_cmd_nxt != CMD_MANUAL;

    if (run_manual) begin
      // Manual control re-applies the last command; anything unknown stops the car.
      issue_nxt = 1'b1;
      case (last_cmd_nxt)
        CMD_FRONT, CMD_FRONT2: dir_nxt = DIR_FRONT;
        CMD_BACK,  CMD_BACK2:  dir_nxt = DIR_BACK;
        CMD_LEFT,  CMD_LEFT2:  dir_nxt = DIR_LEFT;
        CMD_RIGHT, CMD_RIGHT2: dir_nxt = DIR_RIGHT;
        default:               dir_nxt = DIR_STOP;
      endcase
      if (dir_nxt == DIR_STOP) begin
        applied_nxt = '0;
      end
    end else if (auto_mode_nxt) begin
      case (phase_nxt)
        PH_SCAN: begin
          if (dc < crash_cm_r) begin
            issue_nxt       = 1'b1;
            dir_nxt         = DIR_BACK;
            phase_start_nxt = s1_now_r;
            phase_nxt       = PH_BACK;
          end else if (fmin < block_front_r) begin
            // Turn away from a close side, else towards the more open side.
            issue_nxt = 1'b1;
            if (dl < block_side_r) begin
              dir_nxt = DIR_RIGHT;
            end else if (dr < block_side_r) begin
              dir_nxt = DIR_LEFT;
            end else if ({1'b0, dl} > {1'b0, dr} + DIFF_LIMIT) begin
              dir_nxt = DIR_LEFT;
            end else if ({1'b0, dr} > {1'b0, dl} + DIFF_LIMIT) begin
              dir_nxt = DIR_RIGHT;
            end else begin
              dir_nxt = DIR_LEFT;
            end
            phase_start_nxt = s1_now_r;
            phase_nxt       = PH_AVOID;
          end else begin
            // Cruising: gentle steering off walls and towards open space.
            issue_nxt = 1'b1;
            if (dl < wall_margin_r) begin
              dir_nxt = DIR_RIGHT;
            end else if (dr < wall_margin_r) begin
              dir_nxt = DIR_LEFT;
            end else if (dl >= OPEN_SIDE_CM && dr < OPEN_SIDE_CM) begin
              dir_nxt = DIR_LEFT;
            end else if (dr >= OPEN_SIDE_CM && dl < OPEN_SIDE_CM) begin
              dir_nxt = DIR_RIGHT;
            end else begin
              dir_nxt = DIR_FRONT;
            end
          end
        end
        PH_AVOID: begin
          if (fmin > block_front_r || phase_elapsed >= {16'd0, avoid_time_r}) begin
            phase_nxt = PH_SCAN;
          end
        end
        PH_BACK: begin
          // The stop at the end of reversing leaves the applied speed alone.
          if (phase_elapsed >= {16'd0, back_time_r}) begin
            issue_nxt = 1'b1;
            dir_nxt   = DIR_STOP;
            phase_nxt = PH_SCAN;
          end
        end
        default: begin
          phase_nxt = PH_SCAN;
        end
      endcase
    end

    // A moving command drives at, and records, the current setpoint.
    if (issue_nxt && dir_nxt != DIR_STOP) begin
      pct_nxt     = setpoint_nxt;
      applied_nxt = setpoint_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_mode_r    <= 1'b0;
      phase_r        <= PH_STOP;
      phase_start_r  <= '0;
      last_cmd_r     <= '0;
      setpoint_r     <= SETPOINT_RESET;
      applied_r      <= '0;
      derate_start_r <= '0;
    end else if (fire) begin
      auto_mode_r    <= auto_mode_nxt;
      phase_r        <= phase_nxt;
      phase_start_r  <= phase_start_nxt;
      last_cmd_r     <= last_cmd_nxt;
      setpoint_r     <= setpoint_nxt;
      applied_r      <= applied_nxt;
      derate_start_r <= derate_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      issue_r      <= issue_nxt;
      dir_r        <= dir_nxt;
      pct_r        <= pct_nxt;
      echo_valid_r <= s1_cmd_valid_r;
      echo_byte_r  <= s1_cmd_valid_r ? s1_cmd_r : 8'd0;
      dangers_r    <= dangers;
      step_r       <= step;
      tracker_r    <= (applied_nxt == '0);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_drive_issue    = issue_r;
  assign out_drive_dir      = dir_r;
  assign out_drive_pct      = pct_r;
  assign out_echo_valid     = echo_valid_r;
  assign out_echo_byte      = echo_byte_r;
  assign out_danger_total   = dangers_r;
  assign out_reduction_pct  = step_r;
  assign out_tracker_enable = tracker_r;

endmodule

// File: rtl/core/oadc_checker.sv
// Port-level checker for the obstacle-avoiding drive controller, with its bind.
module oadc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_drive_issue,
  input logic [2:0] out_drive_dir,
  input logic [6:0] out_drive_pct,
  input logic       out_echo_valid,
  input logic [7:0] out_echo_byte,
  input logic [1:0] out_danger_total,
  input logic [2:0] out_reduction_pct
);
  import oadc_pkg::*;

  // A stalled result word holds its motor command.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive_dir) && $stable(out_drive_pct))
    else $error("result word changed while stalled");

  // Without an issued command the motor fields stay at stop and zero.
  a_idle_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_drive_issue |-> out_drive_dir == DIR_STOP && out_drive_pct == 7'd0)
    else $error("motor fields set without an issued command");

  // A stop command always carries zero duty.
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_dir == DIR_STOP |-> out_drive_pct == 7'd0)
    else $error("stop issued with non-zero duty");

  // The reduction step follows the danger count.
  a_step_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_danger_total == 2'd0 && out_reduction_pct == 3'd0) ||
                  (out_danger_total == 2'd1 && out_reduction_pct == 3'd1) ||
                  (out_danger_total == 2'd2 && out_reduction_pct == 3'd3) ||
                  (out_danger_total == 2'd3 && out_reduction_pct == 3'd5))
    else $error("reduction step does not match danger count");

  // No echo means a zero echo byte.
  a_echo_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_echo_valid |-> out_echo_byte == 8'd0)
    else $error("echo byte set without an echo");

endmodule

bind obstacle_avoid_drive_controller oadc_checker u_oadc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_drive_issue   (out_drive_issue),
  .out_drive_dir     (out_drive_dir),
  .out_drive_pct     (out_drive_pct),
  .out_echo_valid    (out_echo_valid),
  .out_echo_byte     (out_echo_byte),
  .out_danger_total  (out_danger_total),
  .out_reduction_pct (out_reduction_pct)
);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the obstacle-avoiding drive controller.
`timescale 1ns / 100ps

module tb_top;
  import oadc_pkg::*;

  // Command bytes that the block knows only as "anything else": both must stop the car.
  localparam logic [7:0] HALT_BYTE = 8'h53;
  localparam logic [7:0] JUNK_BYTE = 8'hFF;

  // Cycles without any handshake or register write before the run is declared hung.
  // The longest sender gap and receiver stall, drawn from pause_len, are far shorter, so this is ample.
  localparam int STALL_LIMIT = 1000;
  localparam int PASSES_PER_SETTING = 90;

  // One control-loop pass as it is presented on the input channel.
  typedef struct packed {
    logic [31:0] now;
    logic [7:0]  dl;
    logic [7:0]  dc;
    logic [7:0]  dr;
    logic        temp;
    logic        gas;
    logic        battery;
    logic        cmd_v;
    logic [7:0]  cmd;
  } pass_t;

  // One motor word as it should appear on the result channel.
  typedef struct packed {
    logic       issue;
    logic [2:0] dir;
    logic [6:0] pct;
    logic       echo_v;
    logic [7:0] echo_b;
    logic [1:0] dangers;
    logic [2:0] cut;
    logic       tracker;
  } motor_t;

  typedef struct packed {
    pass_t  p;
    logic   known;
    motor_t want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_now_ms;
  logic [7:0]  in_dist_left_cm;
  logic [7:0]  in_dist_center_cm;
  logic [7:0]  in_dist_right_cm;
  logic        in_temp_danger;
  logic        in_gas_danger;
  logic        in_battery_danger;
  logic        in_cmd_valid;
  logic [7:0]  in_cmd_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_drive_issue;
  logic [2:0]  out_drive_dir;
  logic [6:0]  out_drive_pct;
  logic        out_echo_valid;
  logic [7:0]  out_echo_byte;
  logic [1:0]  out_danger_total;
  logic [2:0]  out_reduction_pct;
  logic        out_tracker_enable;

  obstacle_avoid_drive_controller dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_now_ms          (in_now_ms),
    .in_dist_left_cm    (in_dist_left_cm),
    .in_dist_center_cm  (in_dist_center_cm),
    .in_dist_right_cm   (in_dist_right_cm),
    .in_temp_danger     (in_temp_danger),
    .in_gas_danger      (in_gas_danger),
    .in_battery_danger  (in_battery_danger),
    .in_cmd_valid       (in_cmd_valid),
    .in_cmd_byte        (in_cmd_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_drive_issue    (out_drive_issue),
    .out_drive_dir      (out_drive_dir),
    .out_drive_pct      (out_drive_pct),
    .out_echo_valid     (out_echo_valid),
    .out_echo_byte      (out_echo_byte),
    .out_danger_total   (out_danger_total),
    .out_reduction_pct  (out_reduction_pct),
    .out_tracker_enable (out_tracker_enable)
  );

  // Shadow copy of the configuration registers, at the widths the block keeps.
  logic [6:0]  crash_cm, block_fr_cm, block_sd_cm, wall_cm, min_pct;
  logic [15:0] back_ms, avoid_ms, derate_ms;

  // Shadow copy of the loop state.
  logic        in_auto;
  logic [1:0]  drive_phase;
  logic [31:0] phase_t0;
  logic [31:0] derate_t0;
  logic [7:0]  last_cmd;
  logic [6:0]  setpoint;
  logic [6:0]  applied;

  motor_t      next_word;
  motor_t      pending_drive[$];
  row_t        plan[$];
  int          mismatches;
  int          idle_cycles;
  int          words_seen;
  bit          quiet_run;
  logic [31:0] sim_now;

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // A missing echo (zero) or anything beyond a metre reads as a metre.
  function automatic logic [6:0] range_cm(input logic [7:0] raw);
    if (raw == 8'd0 || raw > {1'b0, DIST_CAP}) return DIST_CAP;
    return raw[6:0];
  endfunction

  // Issue a motor command. Moving commands also latch the setpoint as the applied
  // speed; a stop leaves the applied speed alone, which matters at the end of
  // reversing.
  function automatic void steer(input logic [2:0] dir);
    next_word.issue = 1'b1;
    next_word.dir   = dir;
    if (dir == DIR_STOP) begin
      next_word.pct = '0;
    end else begin
      next_word.pct = setpoint;
      applied       = setpoint;
    end
  endfunction

  // Works out the motor word for one pass and advances the shadow loop state.
  function automatic motor_t predict_motor(input pass_t p);
    logic [6:0]  dl, dc, dr, fmin;
    logic [31:0] elapsed;
    int          dangers, cut, diff;
    dl = range_cm(p.dl);
    dc = range_cm(p.dc);
    dr = range_cm(p.dr);
    dangers = int'(p.temp) + int'(p.gas) + int'(p.battery);
    case (dangers)
      0:       cut = 0;
      1:       cut = 1;
      2:       cut = 3;
      default: cut = 5;
    endcase
    next_word = '0;

    // Derating only runs while the car moves under some danger. The floor is
    // enforced by snapping to it, which also lifts a setpoint already below it.
    if (applied == '0 || dangers == 0) begin
      derate_t0 = p.now;
    end else begin
      elapsed = p.now - derate_t0;
      if (elapsed >= {16'd0, derate_ms}) begin
        derate_t0 = p.now;
        if (int'(setpoint) > int'(min_pct) + cut) setpoint = setpoint - 7'(cut);
        else setpoint = min_pct;
      end
    end

    if (p.cmd_v) begin
      last_cmd = p.cmd;
      if (p.cmd == CMD_AUTO) begin
        in_auto     = 1'b1;
        drive_phase = PH_SCAN;
        applied     = '0;
      end else if (p.cmd == CMD_MANUAL) begin
        steer(DIR_STOP);
        in_auto     = 1'b0;
        drive_phase = PH_SCAN;
        applied     = '0;
      end
    end

    if (!in_auto) begin
      // Manual control keeps re-applying the last byte; mode bytes are not re-applied.
      if (last_cmd != CMD_AUTO && last_cmd != CMD_MANUAL) begin
        case (last_cmd)
          CMD_FRONT, CMD_FRONT2: steer(DIR_FRONT);
          CMD_BACK, CMD_BACK2:   steer(DIR_BACK);
          CMD_LEFT, CMD_LEFT2:   steer(DIR_LEFT);
          CMD_RIGHT, CMD_RIGHT2: steer(DIR_RIGHT);
          default: begin
            steer(DIR_STOP);
            applied = '0;
          end
        endcase
      end
    end else begin
      fmin = dc;
      if (dl < fmin) fmin = dl;
      if (dr < fmin) fmin = dr;
      case (drive_phase)
        PH_SCAN: begin
          if (dc < crash_cm) begin
            steer(DIR_BACK);
            phase_t0    = p.now;
            drive_phase = PH_BACK;
          end else if (fmin < block_fr_cm) begin
            diff = int'(dl) - int'(dr);
            if (dl < block_sd_cm) steer(DIR_RIGHT);
            else if (dr < block_sd_cm) steer(DIR_LEFT);
            else if (diff > int'(DIFF_LIMIT)) steer(DIR_LEFT);
            else if (diff < -int'(DIFF_LIMIT)) steer(DIR_RIGHT);
            else steer(DIR_LEFT);
            phase_t0    = p.now;
            drive_phase = PH_AVOID;
          end else begin
            if (dl < wall_cm) steer(DIR_RIGHT);
            else if (dr < wall_cm) steer(DIR_LEFT);
            else if (dl >= OPEN_SIDE_CM && dr < OPEN_SIDE_CM) steer(DIR_LEFT);
            else if (dr >= OPEN_SIDE_CM && dl < OPEN_SIDE_CM) steer(DIR_RIGHT);
            else steer(DIR_FRONT);
          end
        end
        PH_AVOID: begin
          elapsed = p.now - phase_t0;
          if (fmin > block_fr_cm || elapsed >= {16'd0, avoid_ms}) drive_phase = PH_SCAN;
        end
        PH_BACK: begin
          elapsed = p.now - phase_t0;
          if (elapsed >= {16'd0, back_ms}) begin
            steer(DIR_STOP);
            drive_phase = PH_SCAN;
          end
        end
        default: drive_phase = PH_SCAN;
      endcase
    end

    next_word.echo_v  = p.cmd_v;
    next_word.echo_b  = p.cmd_v ? p.cmd : 8'd0;
    next_word.dangers = 2'(dangers);
    next_word.cut     = 3'(cut);
    next_word.tracker = (applied == '0);
    return next_word;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Gap length for either side: mostly none or short, now and then a long one.
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Distances cluster around the thresholds, with some no-echo and out-of-range reads.
  function automatic logic [7:0] pick_distance();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'd0;
    if (r < 16) return 8'($urandom_range(101, 255));
    if (r < 22) return 8'($urandom);
    if (r < 50) return 8'($urandom_range(1, 40));
    return 8'($urandom_range(1, 100));
  endfunction

  function automatic pass_t mk_pass(input logic [31:0] now, input logic [7:0] dl,
                                    input logic [7:0] dc, input logic [7:0] dr,
                                    input logic [2:0] flags, input logic cmd_v,
                                    input logic [7:0] cmd);
    pass_t p;
    p.now     = now;
    p.dl      = dl;
    p.dc      = dc;
    p.dr      = dr;
    p.temp    = flags[2];
    p.gas     = flags[1];
    p.battery = flags[0];
    p.cmd_v   = cmd_v;
    p.cmd     = cmd;
    return p;
  endfunction

  function automatic motor_t mk_word(input logic issue, input logic [2:0] dir,
                                     input logic [6:0] pct, input logic echo_v,
                                     input logic [7:0] echo_b, input logic [1:0] dangers,
                                     input logic [2:0] cut, input logic tracker);
    motor_t w;
    w.issue   = issue;
    w.dir     = dir;
    w.pct     = pct;
    w.echo_v  = echo_v;
    w.echo_b  = echo_b;
    w.dangers = dangers;
    w.cut     = cut;
    w.tracker = tracker;
    return w;
  endfunction

  task automatic add_row(input pass_t p, input logic known, input motor_t want);
    row_t r;
    r.p     = p;
    r.known = known;
    r.want  = want;
    plan.push_back(r);
  endtask

  // Presents one pass and holds it until the block takes it. Valid is lowered
  // only when a gap follows, so it is never dropped and raised in one step.
  // A hand-typed expectation, where the row has one, replaces the predicted word,
  // but the predictor still runs so that its state keeps in step.
  task automatic send_pass(input pass_t p, input logic known, input motor_t want);
    int     gap;
    motor_t w;
    gap = quiet_run ? 0 : pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_now_ms         <= p.now;
    in_dist_left_cm   <= p.dl;
    in_dist_center_cm <= p.dc;
    in_dist_right_cm  <= p.dr;
    in_temp_danger    <= p.temp;
    in_gas_danger     <= p.gas;
    in_battery_danger <= p.battery;
    in_cmd_valid      <= p.cmd_v;
    in_cmd_byte       <= p.cmd;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    w = predict_motor(p);
    pending_drive.push_back(known ? want : w);
  endtask

  // Prints one line per mismatch and counts it.
  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    $display("ERROR at %0t: word %0d %s: expected 0x%0h, got 0x%0h",
             $realtime, words_seen, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Result channel: random back-pressure and the scoreboard
  // ---------------------------------------------------------------------------

  // Ready is held low for a random stall and then raised for a random stretch. In a
  // quiet stretch the receiver never stalls.
  initial begin : result_stalls
    int n;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (quiet_run) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = pause_len();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Every accepted result word is compared with the oldest predicted word.
  always @(posedge clk) begin : check_word
    motor_t w;
    if (out_valid === 1'b1 && out_ready === 1'b1) begin
      words_seen++;
      if (pending_drive.size() == 0) begin
        flag_mismatch("arrived with nothing expected", 0, 0);
      end else begin
        w = pending_drive.pop_front();
        if (out_drive_issue !== w.issue)
          flag_mismatch("drive_issue", w.issue, out_drive_issue);
        if (out_drive_dir !== w.dir)
          flag_mismatch("drive_dir", w.dir, out_drive_dir);
        if (out_drive_pct !== w.pct)
          flag_mismatch("drive_pct", w.pct, out_drive_pct);
        if (out_echo_valid !== w.echo_v)
          flag_mismatch("echo_valid", w.echo_v, out_echo_valid);
        if (out_echo_byte !== w.echo_b)
          flag_mismatch("echo_byte", w.echo_b, out_echo_byte);
        if (out_danger_total !== w.dangers)
          flag_mismatch("danger_total", w.dangers, out_danger_total);
        if (out_reduction_pct !== w.cut)
          flag_mismatch("reduction_pct", w.cut, out_reduction_pct);
        if (out_tracker_enable !== w.tracker)
          flag_mismatch("tracker_enable", w.tracker, out_tracker_enable);
      end
    end
  end

  // Watchdog: any handshake or register write restarts the count of dead cycles.
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_ready === 1'b1) ||
        (out_valid === 1'b1 && out_ready === 1'b1) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("obstacle_avoid_drive_controller: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int          i, k, ph, r;
    pass_t       nx;
    logic [15:0] cfg_vals [8];

    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_valid          = 1'b0;
    in_now_ms         = '0;
    in_dist_left_cm   = '0;
    in_dist_center_cm = '0;
    in_dist_right_cm  = '0;
    in_temp_danger    = 1'b0;
    in_gas_danger     = 1'b0;
    in_battery_danger = 1'b0;
    in_cmd_valid      = 1'b0;
    in_cmd_byte       = '0;
    mismatches        = 0;
    idle_cycles       = 0;
    words_seen        = 0;
    quiet_run         = 1'b0;

    // The shadow state starts where the block comes out of reset.
    crash_cm    = 7'd10;
    block_fr_cm = 7'd30;
    block_sd_cm = 7'd20;
    wall_cm     = 7'd15;
    back_ms     = 16'd250;
    avoid_ms    = 16'd40;
    derate_ms   = 16'd1000;
    min_pct     = 7'd30;
    in_auto     = 1'b0;
    drive_phase = PH_STOP;
    phase_t0    = '0;
    derate_t0   = '0;
    last_cmd    = '0;
    setpoint    = SETPOINT_RESET;
    applied     = '0;

    // Directed table, run with the reset settings. Rows whose word is obvious
    // carry it typed in; the rest lean on the predictor.
    // Out of reset the last command is zero, which manual control treats as an
    // unknown byte and answers with a stop. Distances of zero and 255 both cap.
    add_row(mk_pass(32'd0, 8'd0, 8'd0, 8'd0, 3'b000, 1'b0, 8'd0), 1'b1,
            mk_word(1'b1, DIR_STOP, 7'd0, 1'b0, 8'd0, 2'd0, 3'd0, 1'b1));
    // All three dangers while parked: largest step reported, nothing derated.
    add_row(mk_pass(32'd5, 8'd255, 8'd255, 8'd255, 3'b111, 1'b0, 8'd0), 1'b1,
            mk_word(1'b1, DIR_STOP, 7'd0, 1'b0, 8'd0, 2'd3, 3'd5, 1'b1));
    // Drive forward at the reset setpoint.
    add_row(mk_pass(32'd10, 8'd60, 8'd60, 8'd60, 3'b000, 1'b1, CMD_FRONT), 1'b1,
            mk_word(1'b1, DIR_FRONT, 7'd80, 1'b1, CMD_FRONT, 2'd0, 3'd0, 1'b0));
    // One danger, derate period not yet over: speed unchanged.
    add_row(mk_pass(32'd20, 8'd60, 8'd60, 8'd60, 3'b100, 1'b0, 8'd0), 1'b1,
            mk_word(1'b1, DIR_FRONT, 7'd80, 1'b0, 8'd0, 2'd1, 3'd1, 1'b0));
    // Period over: one step off for one danger, then five, then three.
    add_row(mk_pass(32'd1020, 8'd60, 8'd60, 8'd60, 3'b100, 1'b0, 8'd0), 1'b1,
            mk_word(1'b1, DIR_FRONT, 7'd79, 1'b0, 8'd0, 2'd1, 3'd1, 1'b0));
    add_row(mk_pass(32'd2020, 8'd60, 8'd60, 8'd60, 3'b111, 1'b0, 8'd0), 1'b1,
            mk_word(1'b1, DIR_FRONT, 7'd74, 1'b0, 8'd0, 2'd3, 3'd5, 1'b0));
    add_row(mk_pass(32'd3020, 8'd60, 8'd60, 8'd60, 3'b011, 1'b0, 8'd0), 1'b1,
            mk_word(1'b1, DIR_FRONT, 7'd71, 1'b0, 8'd0, 2'd2, 3'd3, 1'b0));
    // The remaining manual drive letters.
    add_row(mk_pass(32'd3021, 8'd60, 8'd60, 8'd60, 3'b000, 1'b1, CMD_FRONT2), 1'b0, '0);
    add_row(mk_pass(32'd3022, 8'd60, 8'd60, 8'd60, 3'b000, 1'b1, CMD_BACK), 1'b0, '0);
    add_row(mk_pass(32'd3023, 8'd60, 8'd60, 8'd60, 3'b000, 1'b1, CMD_BACK2), 1'b0, '0);
    add_row(mk_pass(32'd3024, 8'd60, 8'd60, 8'd60, 3'b000, 1'b1, CMD_LEFT), 1'b0, '0);
    add_row(mk_pass(32'd3025, 8'd60, 8'd60, 8'd60, 3'b000, 1'b1, CMD_LEFT2), 1'b0, '0);
    add_row(mk_pass(32'd3026, 8'd60, 8'd60, 8'd60, 3'b000, 1'b1, CMD_RIGHT), 1'b0, '0);
    add_row(mk_pass(32'd3027, 8'd60, 8'd60, 8'd60, 3'b000, 1'b1, CMD_RIGHT2), 1'b0, '0);
    // Unknown bytes stop the car and clear the applied speed.
    add_row(mk_pass(32'd3028, 8'd60, 8'd60, 8'd60, 3'b000, 1'b1, HALT_BYTE), 1'b1,
            mk_word(1'b1, DIR_STOP, 7'd0, 1'b1, HALT_BYTE, 2'd0, 3'd0, 1'b1));
    add_row(mk_pass(32'd3029, 8'd60, 8'd60, 8'd60, 3'b000, 1'b1, JUNK_BYTE), 1'b1,
            mk_word(1'b1, DIR_STOP, 7'd0, 1'b1, JUNK_BYTE, 2'd0, 3'd0, 1'b1));
    // Manual mode byte stops at once; on the next pass it is not re-applied.
    add_row(mk_pass(32'd3030, 8'd60, 8'd60, 8'd60, 3'b000, 1'b1, CMD_MANUAL), 1'b1,
            mk_word(1'b1, DIR_STOP, 7'd0, 1'b1, CMD_MANUAL, 2'd0, 3'd0, 1'b1));
    add_row(mk_pass(32'd3031, 8'd60, 8'd60, 8'd60, 3'b000, 1'b0, 8'd0), 1'b1,
            mk_word(1'b0, DIR_STOP, 7'd0, 1'b0, 8'd0, 2'd0, 3'd0, 1'b1));
    // Auto mode: open road, then an open left side, then an obstacle near the
    // left that sends the car right into the avoid phase.
    add_row(mk_pass(32'd4000, 8'd100, 8'd100, 8'd100, 3'b000, 1'b1, CMD_AUTO), 1'b0, '0);
    add_row(mk_pass(32'd4001, 8'd90, 8'd100, 8'd40, 3'b000, 1'b0, 8'd0), 1'b0, '0);
    add_row(mk_pass(32'd4002, 8'd25, 8'd80, 8'd60, 3'b000, 1'b0, 8'd0), 1'b0, '0);
    // Still blocked and the avoid time not over: no command. Then it times out.
    add_row(mk_pass(32'd4003, 8'd25, 8'd80, 8'd60, 3'b000, 1'b0, 8'd0), 1'b0, '0);
    add_row(mk_pass(32'd4042, 8'd25, 8'd80, 8'd60, 3'b000, 1'b0, 8'd0), 1'b0, '0);
    // Too close ahead: reverse, and at the end of reversing stop with the applied
    // speed kept.
    add_row(mk_pass(32'd4043, 8'd60, 8'd5, 8'd60, 3'b000, 1'b0, 8'd0), 1'b0, '0);
    add_row(mk_pass(32'd4293, 8'd60, 8'd5, 8'd60, 3'b000, 1'b0, 8'd0), 1'b0, '0);
    // Right side inside the side margin: turn left and avoid. Then back to manual.
    add_row(mk_pass(32'd4294, 8'd50, 8'd25, 8'd19, 3'b000, 1'b0, 8'd0), 1'b0, '0);
    add_row(mk_pass(32'd4295, 8'd50, 8'd25, 8'd19, 3'b000, 1'b1, CMD_MANUAL), 1'b0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[j]) send_pass(plan[j].p, plan[j].known, plan[j].want);

    // Random part: several register settings, each followed by a run of passes.
    // Settings 1 and 2 are the all-low and all-high extremes; the last one puts
    // the reset values back by writing them.
    for (ph = 0; ph < 8; ph++) begin
      // Let the block drain before touching any register.
      in_valid <= 1'b0;
      while (pending_drive.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);

      quiet_run = (ph == 2 || ph == 5);
      for (i = 0; i < 8; i++) begin
        case (ph)
          1: cfg_vals[i] = 16'h0000;
          2: cfg_vals[i] = 16'hFFFF;
          7: begin
            case (3'(i))
              REG_CRASH:      cfg_vals[i] = 16'd10;
              REG_BLOCK_FR:   cfg_vals[i] = 16'd30;
              REG_BLOCK_SD:   cfg_vals[i] = 16'd20;
              REG_WALL:       cfg_vals[i] = 16'd15;
              REG_BACK_TIME:  cfg_vals[i] = 16'd250;
              REG_AVOID_TIME: cfg_vals[i] = 16'd40;
              REG_DERATE:     cfg_vals[i] = 16'd1000;
              default:        cfg_vals[i] = 16'd30;
            endcase
          end
          default: begin
            // Short timers keep the phase machine moving; now and then a raw
            // 16-bit value checks that the narrow registers drop the upper bits.
            r = $urandom_range(0, 99);
            if (r < 12) cfg_vals[i] = 16'($urandom);
            else if (3'(i) == REG_BACK_TIME || 3'(i) == REG_AVOID_TIME)
              cfg_vals[i] = 16'($urandom_range(0, 400));
            else if (3'(i) == REG_DERATE) cfg_vals[i] = 16'($urandom_range(0, 300));
            else cfg_vals[i] = 16'($urandom_range(0, 100));
          end
        endcase
      end

      if (ph != 0) begin
        for (i = 0; i < 8; i++) begin
          cfg_we    <= 1'b1;
          cfg_index <= 3'(i);
          cfg_wdata <= cfg_vals[i];
          @(posedge clk);
          case (3'(i))
            REG_CRASH:      crash_cm    = cfg_vals[i][6:0];
            REG_BLOCK_FR:   block_fr_cm = cfg_vals[i][6:0];
            REG_BLOCK_SD:   block_sd_cm = cfg_vals[i][6:0];
            REG_WALL:       wall_cm     = cfg_vals[i][6:0];
            REG_BACK_TIME:  back_ms     = cfg_vals[i];
            REG_AVOID_TIME: avoid_ms    = cfg_vals[i];
            REG_DERATE:     derate_ms   = cfg_vals[i];
            REG_MIN_SPEED:  min_pct     = cfg_vals[i][6:0];
            default:        ;
          endcase
        end
        cfg_we <= 1'b0;
      end

      // One setting starts just short of the timestamp wrap.
      sim_now = (ph == 3) ? 32'hFFFF_FF00 : $urandom;

      for (k = 0; k < PASSES_PER_SETTING; k++) begin
        // Time mostly creeps forward, sometimes leaps past the timers, and
        // rarely jumps anywhere at all.
        r = $urandom_range(0, 99);
        if (r < 2) sim_now = $urandom;
        else if (r < 62) sim_now = sim_now + $urandom_range(0, 15);
        else if (r < 92) sim_now = sim_now + $urandom_range(16, 300);
        else sim_now = sim_now + $urandom_range(301, 3000);

        nx.now     = sim_now;
        nx.dl      = pick_distance();
        nx.dc      = pick_distance();
        nx.dr      = pick_distance();
        nx.temp    = ($urandom_range(0, 9) < 3);
        nx.gas     = ($urandom_range(0, 9) < 3);
        nx.battery = ($urandom_range(0, 9) < 3);
        nx.cmd_v   = ($urandom_range(0, 4) == 0);

        // Mode bytes are favoured so that auto mode gets long runs of its own.
        r = $urandom_range(0, 99);
        if (!nx.cmd_v || r >= 88) nx.cmd = 8'($urandom);
        else if (r < 30) nx.cmd = CMD_AUTO;
        else if (r < 40) nx.cmd = CMD_MANUAL;
        else if (r < 48) nx.cmd = HALT_BYTE;
        else begin
          case ($urandom_range(0, 7))
            0:       nx.cmd = CMD_FRONT;
            1:       nx.cmd = CMD_FRONT2;
            2:       nx.cmd = CMD_BACK;
            3:       nx.cmd = CMD_BACK2;
            4:       nx.cmd = CMD_LEFT;
            5:       nx.cmd = CMD_LEFT2;
            6:       nx.cmd = CMD_RIGHT;
            default: nx.cmd = CMD_RIGHT2;
          endcase
        end
        send_pass(nx, 1'b0, '0);
      end
    end

    // Drain, then wait on so that the two-register pipeline can show any
    // stray word. A word that never arrives leaves the watchdog to end the run.
    in_valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("obstacle_avoid_drive_controller: match");
    end else begin
      $display("obstacle_avoid_drive_controller: mismatch");
    end
    $finish;
  end

endmodule
